### sv/smteq_pkg.sv
package smteq_pkg;

  localparam int TIME_BITS = 32;
  localparam int KIND_FIELD_BITS = 4;

  typedef enum logic {
    CMD_ENQUEUE,
    CMD_DEQUEUE
  } command_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_NEGATIVE,
    ST_EMPTY,
    ST_FULL
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT
  } seq_state_t;

  typedef struct packed {
    command_t                      command;
    logic signed [TIME_BITS-1:0]   event_time;
    logic [KIND_FIELD_BITS-1:0]    event_kind;
  } in_item_t;

  typedef struct packed {
    status_t                       status;
    logic signed [TIME_BITS-1:0]   out_time;
    logic [KIND_FIELD_BITS-1:0]    out_kind;
  } out_item_t;

endpackage

### sv/stable_min_time_event_queue.sv
// Enqueue: busy stays low; the result strobes on done in the cycle after start.
// Dequeue from n held events: busy through a scan of all n
// entries through one comparator, then compaction of the entries after the
// winner, one read and one write per cycle; done strobes as busy drops.
// Empty dequeue answers like an enqueue. The receiver cannot stall results.
// Synchronous reset empties the queue; store contents are left as they are.
module stable_min_time_event_queue #(
  parameter int CAPACITY = 16,
  parameter int KIND_BITS = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  smteq_pkg::in_item_t    item,
  output logic                   busy,
  output logic                   done,
  output smteq_pkg::out_item_t   result
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int TW = smteq_pkg::TIME_BITS;
  localparam int KF = smteq_pkg::KIND_FIELD_BITS;

  smteq_pkg::seq_state_t state, state_next;

  logic [CW-1:0]           count;
  logic [CW-1:0]           ptr;
  logic                    rvld;
  logic [AW-1:0]           ridx;
  logic [AW-1:0]           best;
  logic signed [TW-1:0]    best_time;
  logic [KIND_BITS-1:0]    best_kind;

  logic                    rd_en;
  logic [AW-1:0]           rd_addr;
  logic signed [TW-1:0]    rd_time;
  logic [KIND_BITS-1:0]    rd_kind;
  logic                    wr_en;
  logic [AW-1:0]           wr_addr;
  logic signed [TW-1:0]    wr_time;
  logic [KIND_BITS-1:0]    wr_kind;

  logic                    accept;
  logic                    is_deq;
  logic                    full;
  logic                    enq_ok;
  logic                    issue;
  logic                    scan_end;
  logic                    shift_end;
  logic                    take_new;
  logic [KIND_BITS+KF-1:0] kind_in_ext;
  logic [KIND_BITS+KF-1:0] kind_out_ext;
  logic [KIND_BITS-1:0]    kind_in;

  assign kind_in_ext  = {{KIND_BITS{1'b0}}, item.event_kind};
  assign kind_in      = kind_in_ext[KIND_BITS-1:0];
  assign kind_out_ext = {{KF{1'b0}}, best_kind};

  assign accept    = start && !busy;
  assign is_deq    = (item.command == smteq_pkg::CMD_DEQUEUE);
  assign full      = (count == CW'(CAPACITY));
  assign enq_ok    = accept && !is_deq && !item.event_time[TW-1] && !full;
  assign issue     = ((state == smteq_pkg::S_SCAN) || (state == smteq_pkg::S_SHIFT))
                     && (ptr != count);
  assign scan_end  = (state == smteq_pkg::S_SCAN) && (ptr == count) && !rvld;
  assign shift_end = (state == smteq_pkg::S_SHIFT) && (ptr == count) && !rvld;

  // shared comparator: strict less keeps the earliest entry on ties
  assign take_new  = (state == smteq_pkg::S_SCAN) && rvld
                     && ((ridx == '0) || (rd_time < best_time));

  smteq_store #(
    .DEPTH     (CAPACITY),
    .KIND_BITS (KIND_BITS)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_time (wr_time),
    .wr_kind (wr_kind),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_time (rd_time),
    .rd_kind (rd_kind)
  );

  always_comb begin
    state_next = state;
    case (state)
      smteq_pkg::S_IDLE: begin
        if (accept && is_deq && (count != '0)) state_next = smteq_pkg::S_SCAN;
      end
      smteq_pkg::S_SCAN: begin
        if (scan_end) state_next = smteq_pkg::S_SHIFT;
      end
      smteq_pkg::S_SHIFT: begin
        if (shift_end) state_next = smteq_pkg::S_IDLE;
      end
      default: state_next = smteq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    busy    = 1'b1;
    rd_en   = issue;
    rd_addr = ptr[AW-1:0];
    wr_en   = 1'b0;
    wr_addr = count[AW-1:0];
    wr_time = item.event_time;
    wr_kind = kind_in;
    case (state)
      smteq_pkg::S_IDLE: begin
        busy  = 1'b0;
        wr_en = enq_ok;
      end
      smteq_pkg::S_SCAN: begin
        wr_en = 1'b0;
      end
      smteq_pkg::S_SHIFT: begin
        // entry read last cycle moves down one slot
        wr_en   = rvld;
        wr_addr = ridx - 1'b1;
        wr_time = rd_time;
        wr_kind = rd_kind;
      end
      default: busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= smteq_pkg::S_IDLE;
      count <= '0;
      ptr   <= '0;
      rvld  <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      rvld  <= issue;
      done  <= 1'b0;
      if (issue) ptr <= ptr + 1'b1;

      if (accept) begin
        ptr <= '0;
        if (!is_deq) begin
          done            <= 1'b1;
          result.out_time <= '0;
          result.out_kind <= '0;
          if (item.event_time[TW-1]) begin
            result.status <= smteq_pkg::ST_NEGATIVE;
          end else if (full) begin
            result.status <= smteq_pkg::ST_FULL;
          end else begin
            result.status <= smteq_pkg::ST_OK;
            count         <= count + 1'b1;
          end
        end else if (count == '0) begin
          done            <= 1'b1;
          result.status   <= smteq_pkg::ST_EMPTY;
          result.out_time <= '0;
          result.out_kind <= '0;
        end
      end

      if (scan_end) ptr <= CW'(best) + CW'(1);

      if (shift_end) begin
        count           <= count - 1'b1;
        done            <= 1'b1;
        result.status   <= smteq_pkg::ST_OK;
        result.out_time <= best_time;
        result.out_kind <= kind_out_ext[KF-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    ridx <= ptr[AW-1:0];
    if (take_new) begin
      best      <= ridx;
      best_time <= rd_time;
      best_kind <= rd_kind;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("held count above capacity");

  a_enq_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.command == smteq_pkg::CMD_ENQUEUE) |=> (done && !busy))
    else $error("enqueue result not delivered in the next cycle");

  a_deq_count: assert property (@(posedge clk) disable iff (rst)
    (done && $past(state == smteq_pkg::S_SHIFT)) |->
      (CW'(count + 1'b1) == $past(count)))
    else $error("dequeue did not remove exactly one entry");

  a_shift_past_best: assert property (@(posedge clk) disable iff (rst)
    (state == smteq_pkg::S_SHIFT) |-> (ptr > CW'(best)))
    else $error("compaction pointer at or below removed entry");

  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    (done && result.status == smteq_pkg::ST_EMPTY) |-> (count == '0))
    else $error("empty status with events held");

endmodule

### sv/smteq_store.sv
module smteq_store #(
  parameter int DEPTH = 16,
  parameter int KIND_BITS = 4
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [$clog2(DEPTH)-1:0]                 wr_addr,
  input  logic signed [smteq_pkg::TIME_BITS-1:0]   wr_time,
  input  logic [KIND_BITS-1:0]                     wr_kind,
  input  logic                                     rd_en,
  input  logic [$clog2(DEPTH)-1:0]                 rd_addr,
  output logic signed [smteq_pkg::TIME_BITS-1:0]   rd_time,
  output logic [KIND_BITS-1:0]                     rd_kind
);

  logic signed [smteq_pkg::TIME_BITS-1:0] time_mem [DEPTH];
  logic [KIND_BITS-1:0]                   kind_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      time_mem[wr_addr] <= wr_time;
      kind_mem[wr_addr] <= wr_kind;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_time <= time_mem[rd_addr];
      rd_kind <= kind_mem[rd_addr];
    end
  end

endmodule
